FILE: design/bcp_pkg.sv
package bcp_pkg;

   localparam int STEP_BITS = 32;
   localparam int FIELD_W   = 32;
   localparam int SLOT_W    = 16;
   localparam int WORD_W    = 64;
   localparam int T_W       = 16;
   localparam int OP_W      = 17;
   localparam int CNT_W     = $clog2(WORD_W);
   localparam int REQ_W     = 80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TEST,
      ST_MUL,
      ST_DIV,
      ST_DONE,
      ST_PICK,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_LOOP,
      OP_B1,
      OP_B2,
      OP_B3,
      OP_B4,
      OP_B5
   } op_type;

   function automatic logic signed [WORD_W-1:0] step_value(input logic [FIELD_W-1:0] raw);
      step_value = {{(WORD_W-STEP_BITS){raw[STEP_BITS-1]}}, raw[STEP_BITS-1:0]};
   endfunction

endpackage

FILE: design/binomial_checkpoint_placement_unit.sv
// Binomial (revolve) checkpoint placement. One request carries the step of the last stored
// checkpoint, the free slot count and the end step; one response returns the step for the
// next checkpoint, or -1 when the request is invalid. Multiplications and divisions run through
// a single shared shift-add multiplier and restoring divider computing (a * m) / d; a valid
// request searches the repetition number t upward from 1 (at most 65535 in its 16-bit register),
// while invalid requests skip the arithmetic and answer directly. The request side is ready
// only while no request is in flight.
module binomial_checkpoint_placement_unit
   import bcp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,    // last_step[31:0], free_slots[47:32], end_step[79:48]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [FIELD_W-1:0] rsp_tdata   // next_step[31:0]
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic signed [WORD_W-1:0] last_ff, last_in, end_ff, end_in;
   logic [SLOT_W-1:0]  s_ff, s_in;
   logic [WORD_W-1:0]  n_ff, n_in;
   logic [T_W-1:0]     t_ff, t_in;
   logic [WORD_W-1:0]  ub_ff, ub_in;
   logic [WORD_W-1:0]  b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in, b5_ff, b5_in;
   logic [WORD_W-1:0]  a_ff, a_in, acc_ff, acc_in;
   logic [OP_W-1:0]    m_ff, m_in, d_ff, d_in, rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] res_ff, res_in, rsp_data_ff, rsp_data_in;

   logic signed [WORD_W-1:0] span;
   logic [OP_W:0]      rem_sh, diff;
   logic               launch;
   logic [WORD_W-1:0]  la;
   logic [OP_W-1:0]    lm, ld;
   op_type             lop;
   logic [OP_W-1:0]    s_ext, t_ext, st_sum;
   logic [T_W-1:0]     t_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign span   = end_ff - last_ff;
   assign s_ext  = {{(OP_W-SLOT_W){1'b0}}, s_ff};
   assign t_ext  = {{(OP_W-T_W){1'b0}}, t_ff};
   assign st_sum = s_ext + t_ext;
   assign t_next = t_ff + 1'b1;
   assign rem_sh = {rem_ff, acc_ff[WORD_W-1]};
   assign diff   = rem_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      last_ff     <= last_in;
      end_ff      <= end_in;
      s_ff        <= s_in;
      n_ff        <= n_in;
      t_ff        <= t_in;
      ub_ff       <= ub_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      b5_ff       <= b5_in;
      a_ff        <= a_in;
      acc_ff      <= acc_in;
      m_ff        <= m_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      s_in         = s_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      ub_in        = ub_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      launch       = 1'b0;
      la           = ub_ff;
      lm           = t_ext;
      ld           = st_sum;
      lop          = OP_LOOP;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in  = step_value(req_tdata[FIELD_W-1:0]);
               s_in     = req_tdata[FIELD_W+SLOT_W-1:FIELD_W];
               end_in   = step_value(req_tdata[REQ_W-1:FIELD_W+SLOT_W]);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (s_ff < SLOT_W'(2) || last_ff < 0 || end_ff <= 0 || span < 2) begin
               res_in   = '1;
               state_in = ST_OUT;
            end else begin
               n_in     = span;
               t_in     = '0;
               ub_in    = WORD_W'(1);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            launch = 1'b1;
            if (ub_ff < n_ff) begin
               t_in = t_next;
               la   = ub_ff;
               lm   = st_sum + 1'b1;
               ld   = {{(OP_W-T_W){1'b0}}, t_next};
               lop  = OP_LOOP;
            end else begin
               la  = ub_ff;
               lm  = t_ext;
               ld  = st_sum;
               lop = OP_B1;
            end
         end
         ST_MUL: begin
            acc_in = {acc_ff[WORD_W-2:0], 1'b0} + (m_ff[OP_W-1] ? a_ff : '0);
            m_in   = {m_ff[OP_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(WORD_W-1);
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, d_ff}) begin
               rem_in = diff[OP_W-1:0];
               acc_in = {acc_ff[WORD_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[OP_W-1:0];
               acc_in = {acc_ff[WORD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            case (op_ff)
               OP_LOOP: begin
                  ub_in    = acc_ff;
                  state_in = ST_TEST;
               end
               OP_B1: begin
                  b1_in  = acc_ff;
                  launch = 1'b1;
                  la     = acc_ff;
                  lm     = s_ext;
                  ld     = st_sum - 1'b1;
                  lop    = OP_B2;
               end
               OP_B2: begin
                  b2_in  = acc_ff;
                  launch = 1'b1;
                  la     = acc_ff;
                  lm     = t_ext - 1'b1;
                  ld     = st_sum - OP_W'(2);
                  lop    = OP_B3;
               end
               OP_B3: begin
                  b3_in  = acc_ff;
                  launch = 1'b1;
                  la     = b2_ff;
                  lm     = t_ext - 1'b1;
                  ld     = s_ext;
                  lop    = OP_B4;
               end
               OP_B4: begin
                  b4_in  = acc_ff;
                  launch = 1'b1;
                  la     = b3_ff;
                  lm     = s_ext - OP_W'(2);
                  ld     = t_ext;
                  lop    = OP_B5;
               end
               OP_B5: begin
                  b5_in    = acc_ff;
                  state_in = ST_PICK;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PICK: begin
            if (n_ff <= b1_ff + b3_ff) begin
               res_in = last_ff[FIELD_W-1:0] + b4_ff[FIELD_W-1:0];
            end else if (n_ff + b5_ff >= ub_ff) begin
               res_in = last_ff[FIELD_W-1:0] + b1_ff[FIELD_W-1:0];
            end else begin
               res_in = end_ff[FIELD_W-1:0] - b2_ff[FIELD_W-1:0] - b3_ff[FIELD_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (launch) begin
         a_in     = la;
         m_in     = lm;
         d_in     = ld;
         op_in    = lop;
         acc_in   = '0;
         cnt_in   = CNT_W'(OP_W-1);
         state_in = ST_MUL;
      end
   end

   // divider never sees a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> d_ff != '0)
      else $error("zero divisor in shared divider");

   // a request transfer starts the validity check
   a_req_check: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CHECK)
      else $error("request transfer did not start a check");

   // a new response only comes out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside output state");

   // binomial stays nonzero through the search
   a_ub_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST |-> ub_ff != '0)
      else $error("binomial collapsed to zero");

endmodule
